// ===== hdl/sc2ch_pkg.sv =====
// Shared types and constants for the scan-code to character FIFO.
// Holds request/response structs, scan-code values and the layout tables.
// No dependencies.
`timescale 1ns / 1ps

package sc2ch_pkg;

   localparam logic       OP_SCAN = 1'b0;
   localparam logic       OP_READ = 1'b1;

   localparam logic [7:0] SC_CTRL_MAKE   = 8'h1D;
   localparam logic [7:0] SC_CTRL_BREAK  = 8'h9D;
   localparam logic [7:0] SC_CAPS        = 8'h3A;
   localparam logic [7:0] SC_SHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] SC_SHIFT_BREAK = 8'hAA;
   localparam int         KEY_LIMIT      = 83;
   localparam int         KEY_IDX_W      = $clog2(KEY_LIMIT);

   localparam logic [7:0] CH_EOF   = 8'hFF;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_C = 8'h63;
   localparam logic [7:0] CH_LOW_D = 8'h64;
   localparam logic [7:0] CH_LOW_Z = 8'h7A;

   localparam int FILL_W = 10;

   typedef struct packed {
      logic       operation;
      logic [7:0] scancode;
   } sc2ch_req_type;

   typedef struct packed {
      logic              char_valid;
      logic [7:0]        char_out;
      logic              fifo_empty;
      logic              interrupt_request;
      logic              key_dropped;
      logic [FILL_W-1:0] fill_level;
   } sc2ch_rsp_type;

   // Decoded action for one scan code
   typedef struct packed {
      logic       ctrl_set;
      logic       ctrl_clr;
      logic       caps_tog;
      logic       shift_set;
      logic       shift_clr;
      logic       push;
      logic       irq;
      logic [7:0] data;
   } sc2ch_key_type;

   localparam logic [7:0] PLAIN_MAP [0:KEY_LIMIT-1] = '{
      8'h00, 8'h01, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h27, 8'h3C, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5C, 8'h2B, 8'h0A, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h7B, 8'h7C, 8'h05, 8'h7D, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
      8'h6D, 8'h2C, 8'h2E, 8'h2D, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h12, 8'h00, 8'h13, 8'h00, 8'h00,
      8'h14, 8'h00, 8'h00
   };

   localparam logic [7:0] UPPER_MAP [0:KEY_LIMIT-1] = '{
      8'h00, 8'h01, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2F, 8'h28,
      8'h29, 8'h3D, 8'h3F, 8'h3E, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h5E, 8'h2A, 8'h0A, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h7E,
      8'h5B, 8'h2F, 8'h05, 8'h5D, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
      8'h4D, 8'h3B, 8'h3A, 8'h5F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h11, 8'h00, 8'h00, 8'h12, 8'h00, 8'h13, 8'h00, 8'h00,
      8'h14, 8'h00, 8'h00
   };

endpackage

// ===== hdl/sc2ch_keymap.sv =====
// Scan-code decoder: modifier actions and layout table lookup.
// Depends on sc2ch_pkg.
`timescale 1ns / 1ps

module sc2ch_keymap (
   input  logic [7:0]            scancode,
   input  logic                  shift_held,
   input  logic                  caps_on,
   input  logic                  ctrl_held,
   output sc2ch_pkg::sc2ch_key_type key
);
   import sc2ch_pkg::*;

   logic [KEY_IDX_W-1:0] idx;
   logic [7:0]           base;
   logic [7:0]           upper;
   logic                 alpha_key;
   logic                 use_upper;

   assign idx       = scancode[KEY_IDX_W-1:0];
   assign base      = PLAIN_MAP[idx];
   assign upper     = UPPER_MAP[idx];
   assign alpha_key = (base >= CH_LOW_A) && (base <= CH_LOW_Z);
   assign use_upper = alpha_key ? (shift_held ^ caps_on) : shift_held;

   always_comb begin
      key = '0;
      if (scancode == SC_CTRL_MAKE) begin
         key.ctrl_set = 1'b1;
      end else if (scancode == SC_CTRL_BREAK) begin
         key.ctrl_clr = 1'b1;
      end else if (scancode == SC_CAPS) begin
         key.caps_tog = 1'b1;
      end else if (scancode == SC_SHIFT_MAKE) begin
         key.shift_set = 1'b1;
      end else if (scancode == SC_SHIFT_BREAK) begin
         key.shift_clr = 1'b1;
      end else if (scancode < 8'(KEY_LIMIT)) begin
         if (ctrl_held && base == CH_LOW_C) begin
            key.irq = 1'b1;
         end else if (ctrl_held && base == CH_LOW_D) begin
            key.push = 1'b1;
            key.data = CH_EOF;
         end else begin
            key.push = 1'b1;
            key.data = use_upper ? upper : base;
         end
      end
   end

endmodule

// ===== hdl/sc2ch_store.sv =====
// Character store: one write port, one read port with registered data.
// No package dependencies.
`timescale 1ns / 1ps

module sc2ch_store #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [0:DEPTH-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/scancode_to_char_fifo.sv =====
// Top level: set-1 scan-code decoder feeding a character ring FIFO.
// Depends on sc2ch_pkg, sc2ch_keymap and sc2ch_store.
//
//   channel   handshake            payload     direction
//   request   start / busy         req_data    in  (operation, scancode)
//   response  rsp_valid (strobe)   rsp_data    out (char, flags, fill level)
//
// One request per clock once busy is low; each request yields one response
// in the cycle after its acceptance edge (the store read port's
// registered data sets that timing).
// Synchronous active-high reset clears pointers, count and modifier flags;
// busy stays high for the cycle after reset. Store contents are not cleared.
// Responses are strobes and cannot be stalled; nothing is buffered.
`timescale 1ns / 1ps

module scancode_to_char_fifo #(
   parameter int FIFO_DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  sc2ch_pkg::sc2ch_req_type req_data,
   output logic                     rsp_valid,
   output sc2ch_pkg::sc2ch_rsp_type rsp_data
);
   import sc2ch_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   // Control state
   logic             busy_ff;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             shift_ff, shift_in;
   logic             caps_ff, caps_in;
   logic             ctrl_ff, ctrl_in;

   // Response register
   logic             rsp_valid_ff;
   logic             char_valid_ff, char_valid_in;
   logic             irq_ff, irq_in;
   logic             dropped_ff, dropped_in;

   logic             accept;
   logic             fifo_full;
   logic             do_read;
   logic             do_push;
   sc2ch_key_type    key;
   logic [7:0]       rd_data;
   logic [CNT_W+FILL_W-1:0] count_wide;

   assign accept    = start && !busy_ff;
   assign fifo_full = (count_ff == CNT_W'(FIFO_DEPTH));

   sc2ch_keymap u_keymap (
      .scancode   (req_data.scancode),
      .shift_held (shift_ff),
      .caps_on    (caps_ff),
      .ctrl_held  (ctrl_ff),
      .key        (key)
   );

   // Decode a request into its FIFO and modifier effects
   always_comb begin
      do_read       = 1'b0;
      do_push       = 1'b0;
      char_valid_in = 1'b0;
      irq_in        = 1'b0;
      dropped_in    = 1'b0;
      shift_in      = shift_ff;
      caps_in       = caps_ff;
      ctrl_in       = ctrl_ff;
      if (accept) begin
         if (req_data.operation == OP_READ) begin
            if (count_ff != '0) begin
               do_read       = 1'b1;
               char_valid_in = 1'b1;
            end
         end else begin
            if (key.ctrl_set)  ctrl_in  = 1'b1;
            if (key.ctrl_clr)  ctrl_in  = 1'b0;
            if (key.caps_tog)  caps_in  = !caps_ff;
            if (key.shift_set) shift_in = 1'b1;
            if (key.shift_clr) shift_in = 1'b0;
            irq_in = key.irq;
            if (key.push) begin
               // full FIFO: byte is lost and flagged
               do_push    = !fifo_full;
               dropped_in = fifo_full;
            end
         end
      end
   end

   // Pointer and count update; read and push never happen together
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_W'(1);
      end
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end
   end

   sc2ch_store #(
      .DEPTH  (FIFO_DEPTH),
      .ADDR_W (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (key.data),
      .rd_en   (do_read),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         shift_ff      <= 1'b0;
         caps_ff       <= 1'b0;
         ctrl_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         rd_ptr_ff     <= rd_ptr_in;
         wr_ptr_ff     <= wr_ptr_in;
         count_ff      <= count_in;
         shift_ff      <= shift_in;
         caps_ff       <= caps_in;
         ctrl_ff       <= ctrl_in;
         rsp_valid_ff  <= accept;
      end
   end

   // Response payload, no reset needed
   always_ff @(posedge clock) begin
      char_valid_ff <= char_valid_in;
      irq_ff        <= irq_in;
      dropped_ff    <= dropped_in;
   end

   // count_ff already holds the post-request fill when the strobe is up
   assign count_wide = {{FILL_W{1'b0}}, count_ff};

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data                   = '0;
      rsp_data.char_valid        = char_valid_ff;
      rsp_data.char_out          = char_valid_ff ? rd_data : 8'h00;
      rsp_data.fifo_empty        = (count_ff == '0);
      rsp_data.interrupt_request = irq_ff;
      rsp_data.key_dropped       = dropped_ff;
      rsp_data.fill_level        = count_wide[FILL_W-1:0];
   end

`ifndef SYNTHESIS
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response strobe missing after accepted request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("fill count above FIFO depth");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.key_dropped) |-> fifo_full)
      else $error("key dropped while FIFO had room");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      do_read |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not lower fill count");
`endif

endmodule
